### rtl/core/uss_pkg.sv
`default_nettype none
package uss_pkg;

	localparam int DEF_MAX_CLASSES = 15;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int RESP_W     = 32;
	localparam int CLASS_W    = 4;
	localparam int SIDE_W     = 2;
	localparam int TOTAL_W    = 16;
	localparam int MIN_W      = 16;
	localparam int EFF_W      = 34;
	localparam int MAG_W      = EFF_W + 1;
	localparam int SCORE_W    = 48;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int PROD_W     = ROOT_W + MAG_W;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TREATMENT_CLASSES = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIDE_OBS      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CONTROL_OBS   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TREATMENT_OBS = 4'd3;

	localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_EV_INIT,
		ST_EV_RD,
		ST_EV_CHK,
		ST_EV_DIV,
		ST_EV_UPD,
		ST_EV_NEXT,
		ST_FIN,
		ST_NPROD,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_MUL,
		ST_SAT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

### rtl/core/uplift_split_score_top.sv
`default_nettype none
// Uplift split scorer. Each start beat carries one observation; per group and side counts
// and response sums live in a small memory. A beat without last takes a memory read,
// then a read-modify-write, when its side and group are valid. A beat with last then
// runs the evaluation: for each examined group and side one read and check plus, when
// the group qualifies, one serial division and an update step; then, for a valid split,
// a square root and a shift-add multiply. All of that runs through one divider, one
// root unit and one adder, and busy stays high meanwhile. The result appears for one
// cycle with done high and cannot be held off; all stores are cleared right after.
module uplift_split_score_top
	import uss_pkg::*;
#(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [RESP_W-1:0]      response,
	input  wire logic [CLASS_W-1:0]            group,
	input  wire logic [SIDE_W-1:0]             side,
	input  wire logic                          last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	output logic                               done,
	output logic [SCORE_W-1:0]                 score,
	output logic                               split_valid,
	output logic [TOTAL_W-1:0]                 left_total,
	output logic [TOTAL_W-1:0]                 right_total,
	output logic [CLASS_W-1:0]                 best_class_left,
	output logic [CLASS_W-1:0]                 best_class_right,
	output logic signed [EFF_W-1:0]            effect_left,
	output logic signed [EFF_W-1:0]            effect_right
);
	localparam int NG    = MAX_CLASSES + 1;
	localparam int DEPTH = 2 * NG;
	localparam int CLW   = $clog2(NG);
	localparam int AW    = CLW + 1;
	localparam int CW    = COUNT_WIDTH;
	localparam int SW    = CW + RESP_W;
	localparam int MW    = (CW > MIN_W) ? CW : MIN_W;
	localparam int MCW   = $clog2(MAG_W + 1);

	state_t state_q, state_d;

	logic [CLASS_W-1:0] tc_q;
	logic [MIN_W-1:0]   min_side_q, min_ctrl_q, min_trt_q;

	logic signed [RESP_W-1:0] resp_q;
	logic [CLASS_W-1:0]       grp_q;
	logic                     rgt_q;
	logic                     last_q;
	logic [CW-1:0]            left_q, right_q;

	logic [CLW-1:0]           cls_q;
	logic                     sd_q;
	logic [CLW-1:0]           top_cls;
	logic signed [EFF_W-1:0]  ctrl0_q, ctrl1_q, eff0_q, eff1_q;
	logic [CLASS_W-1:0]       best0_q, best1_q;
	logic                     valid_q;
	logic [SCORE_W-1:0]       score_q;
	logic [2*CW-1:0]          nprod_q;
	logic [ROOT_W-1:0]        root_q;
	logic [MAG_W-1:0]         mag_q;
	logic [PROD_W-1:0]        acc_q;
	logic [MCW-1:0]           mcnt_q;

	logic                     acc_go;
	logic                     rd_en, wr_en, clr, div_start, sqrt_start;
	logic [AW-1:0]            acc_addr, eval_addr, rd_addr;
	logic [CW-1:0]            rd_count;
	logic signed [SW-1:0]     rd_sum;
	logic                     div_done, sqrt_done;
	logic signed [SW-1:0]     div_q;
	logic [ROOT_W-1:0]        sqrt_root;
	logic [MIN_W-1:0]         min_sel;
	logic                     qual, split_ok;
	logic signed [EFF_W-1:0]  mean, ctrl_sel, eff_sel, delta;
	logic signed [MAG_W-1:0]  diff;
	logic [RAD_W-1:0]         nprod_x, radicand;

	assign acc_go = (side == SIDE_LEFT || side == SIDE_RIGHT) &&
		(32'(group) <= 32'(MAX_CLASSES));
	assign acc_addr  = {CLW'(grp_q), rgt_q};
	assign eval_addr = {cls_q, sd_q};
	assign rd_addr   = (state_q == ST_ACC_RD) ? acc_addr : eval_addr;
	assign top_cls   = (32'(tc_q) > 32'(MAX_CLASSES)) ? CLW'(MAX_CLASSES) : CLW'(tc_q);

	assign min_sel = (cls_q == '0) ? min_ctrl_q : min_trt_q;
	assign qual    = (rd_count != '0) && (MW'(rd_count) >= MW'(min_sel));
	assign split_ok = (best0_q != '0) && (best1_q != '0) &&
		(MW'(left_q) >= MW'(min_side_q)) && (MW'(right_q) >= MW'(min_side_q));

	assign mean     = EFF_W'(div_q);
	assign ctrl_sel = sd_q ? ctrl1_q : ctrl0_q;
	assign eff_sel  = sd_q ? eff1_q : eff0_q;
	assign delta    = mean - ctrl_sel;
	assign diff     = MAG_W'(eff0_q) - MAG_W'(eff1_q);

	// A product of counts that overflows 32 bits pins the radicand at all ones.
	assign nprod_x  = RAD_W'(nprod_q);
	assign radicand = (nprod_x[RAD_W-1:ROOT_W] != '0) ? '1 : {nprod_x[ROOT_W-1:0], 32'b0};

	uss_store #(.DEPTH(DEPTH), .AW(AW), .CW(CW), .SW(SW)) u_store (
		.clk(clk), .arst_n(arst_n), .clear(clr),
		.wr_en(wr_en), .wr_addr(acc_addr), .wr_count(rd_count + 1'b1),
		.wr_sum(rd_sum + SW'(resp_q)),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_count(rd_count), .rd_sum(rd_sum)
	);

	uss_div #(.CW(CW), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(rd_sum),
		.divisor(rd_count), .done(div_done), .quotient(div_q)
	);

	uss_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(radicand),
		.done(sqrt_done), .root(sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		clr        = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (acc_go) state_d = ST_ACC_RD;
					else if (last) state_d = ST_EV_INIT;
				end
			end
			ST_ACC_RD: begin
				rd_en   = 1'b1;
				state_d = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				// A full count stops both the count and the sum.
				wr_en   = (rd_count != '1);
				state_d = last_q ? ST_EV_INIT : ST_IDLE;
			end
			ST_EV_INIT: state_d = ST_EV_RD;
			ST_EV_RD: begin
				rd_en   = 1'b1;
				state_d = ST_EV_CHK;
			end
			ST_EV_CHK: begin
				if (qual) begin
					div_start = 1'b1;
					state_d   = ST_EV_DIV;
				end else if (cls_q == '0) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_EV_NEXT;
				end
			end
			ST_EV_DIV: begin
				if (div_done) state_d = ST_EV_UPD;
			end
			ST_EV_UPD: state_d = ST_EV_NEXT;
			ST_EV_NEXT: begin
				if (sd_q && cls_q >= top_cls) state_d = ST_FIN;
				else state_d = ST_EV_RD;
			end
			ST_FIN: state_d = split_ok ? ST_NPROD : ST_OUT;
			ST_NPROD: state_d = ST_SQRT_GO;
			ST_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_d    = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (sqrt_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mcnt_q == MCW'(MAG_W - 1)) state_d = ST_SAT;
			end
			ST_SAT: state_d = ST_OUT;
			ST_OUT: begin
				clr     = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q       <= CLASS_W'(1);
			min_side_q <= MIN_W'(1);
			min_ctrl_q <= MIN_W'(1);
			min_trt_q  <= MIN_W'(1);
			left_q     <= '0;
			right_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TREATMENT_CLASSES: tc_q       <= cfg_data[CLASS_W-1:0];
					REG_MIN_SIDE_OBS:      min_side_q <= cfg_data;
					REG_MIN_CONTROL_OBS:   min_ctrl_q <= cfg_data;
					REG_MIN_TREATMENT_OBS: min_trt_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && start) begin
				if (side == SIDE_LEFT && left_q != '1) left_q <= left_q + 1'b1;
				if (side == SIDE_RIGHT && right_q != '1) right_q <= right_q + 1'b1;
			end else if (clr) begin
				left_q  <= '0;
				right_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					resp_q <= response;
					grp_q  <= group;
					rgt_q  <= (side == SIDE_RIGHT);
					last_q <= last;
				end
			end
			ST_EV_INIT: begin
				cls_q   <= '0;
				sd_q    <= 1'b0;
				best0_q <= '0;
				best1_q <= '0;
				eff0_q  <= '0;
				eff1_q  <= '0;
				valid_q <= 1'b0;
				score_q <= '0;
			end
			ST_EV_UPD: begin
				if (cls_q == '0) begin
					if (sd_q) ctrl1_q <= mean;
					else ctrl0_q <= mean;
				end else if ((sd_q ? best1_q : best0_q) == '0 || eff_sel < delta) begin
					if (sd_q) begin
						eff1_q  <= delta;
						best1_q <= CLASS_W'(cls_q);
					end else begin
						eff0_q  <= delta;
						best0_q <= CLASS_W'(cls_q);
					end
				end
			end
			ST_EV_NEXT: begin
				sd_q <= ~sd_q;
				if (sd_q) cls_q <= cls_q + 1'b1;
			end
			ST_FIN: valid_q <= split_ok;
			ST_NPROD: begin
				nprod_q <= (2*CW)'(left_q) * (2*CW)'(right_q);
				mag_q   <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
			end
			ST_SQRT_WAIT: begin
				root_q <= sqrt_root;
				acc_q  <= '0;
				mcnt_q <= '0;
			end
			ST_MUL: begin
				acc_q  <= {acc_q[PROD_W-2:0], 1'b0} +
					(mag_q[MAG_W-1] ? PROD_W'(root_q) : '0);
				mag_q  <= {mag_q[MAG_W-2:0], 1'b0};
				mcnt_q <= mcnt_q + 1'b1;
			end
			ST_SAT: begin
				score_q <= (acc_q[PROD_W-1:SCORE_W+FRAC_W] != '0) ? '1 :
					acc_q[SCORE_W+FRAC_W-1:FRAC_W];
			end
			default: ;
		endcase
	end

	assign busy             = (state_q != ST_IDLE);
	assign cfg_ready        = 1'b1;
	assign done             = (state_q == ST_OUT);
	assign score            = score_q;
	assign split_valid      = valid_q;
	assign left_total       = TOTAL_W'(left_q);
	assign right_total      = TOTAL_W'(right_q);
	assign best_class_left  = best0_q;
	assign best_class_right = best1_q;
	assign effect_left      = eff0_q;
	assign effect_right     = eff1_q;
endmodule
`default_nettype wire

### rtl/core/uss_store.sv
`default_nettype none
module uss_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int CW    = 16,
	parameter int SW    = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clear,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire logic [CW-1:0]        wr_count,
	input  wire logic signed [SW-1:0] wr_sum,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr,
	output logic [CW-1:0]             rd_count,
	output logic signed [SW-1:0]      rd_sum
);
	logic [CW-1:0]        cnt_mem [DEPTH];
	logic signed [SW-1:0] sum_mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [CW-1:0]        cnt_q;
	logic signed [SW-1:0] sum_q;
	logic                 hit_q;

	// Entries never written since the last clear read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_count;
			sum_mem[wr_addr] <= wr_sum;
		end
		if (rd_en) begin
			cnt_q <= cnt_mem[rd_addr];
			sum_q <= sum_mem[rd_addr];
			hit_q <= vld_q[rd_addr];
		end
	end

	assign rd_count = hit_q ? cnt_q : '0;
	assign rd_sum   = hit_q ? sum_q : '0;
endmodule
`default_nettype wire

### rtl/core/uss_div.sv
`default_nettype none
module uss_div #(
	parameter int CW = 16,
	parameter int SW = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [SW-1:0] dividend,
	input  wire logic [CW-1:0]        divisor,
	output logic                      done,
	output logic signed [SW-1:0]      quotient
);
	localparam int CNT_W = $clog2(SW + 1);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    dq_q;
	logic [CW:0]      rem_q;
	logic [CW-1:0]    dvs_q;
	logic             neg_q;
	logic [CW:0]      rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[CW-1:0], dq_q[SW-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SW - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// Restoring division on the magnitude, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			dq_q  <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dq_q  <= {dq_q[SW-2:0], ge};
		end
	end

	assign quotient = neg_q ? -$signed(dq_q) : $signed(dq_q);
endmodule
`default_nettype wire

### rtl/core/uss_sqrt.sv
`default_nettype none
module uss_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [uss_pkg::RAD_W-1:0]  radicand,
	output logic                            done,
	output logic [uss_pkg::ROOT_W-1:0]      root
);
	import uss_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 2;

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             ge;

	assign rem_sh = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// Digit-by-digit root: two radicand bits per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
	import uss_pkg::*;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               split_ok;
		logic [TOTAL_W-1:0] left_n;
		logic [TOTAL_W-1:0] right_n;
		logic [CLASS_W-1:0] best_l;
		logic [CLASS_W-1:0] best_r;
		logic [EFF_W-1:0]   eff_l;
		logic [EFF_W-1:0]   eff_r;
	} split_result_t;

	class split_board;
		bit [15:0] counts[32];
		longint sums[32];
		bit [15:0] left_n, right_n;
		bit [CLASS_W-1:0] classes;
		bit [MIN_W-1:0] min_side, min_ctl, min_trt;
		split_result_t pending[$];
		int errors;

		function new();
			classes = 1;
			min_side = 1;
			min_ctl = 1;
			min_trt = 1;
			clear_node();
		endfunction

		function void clear_node();
			foreach (counts[i]) begin
				counts[i] = 0;
				sums[i] = 0;
			end
			left_n = 0;
			right_n = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TREATMENT_CLASSES: classes = data[CLASS_W-1:0];
				REG_MIN_SIDE_OBS:      min_side = data;
				REG_MIN_CONTROL_OBS:   min_ctl = data;
				REG_MIN_TREATMENT_OBS: min_trt = data;
				default: ;
			endcase
		endfunction

		function bit mean_of(int g, int s, bit [15:0] minimum, output longint m);
			longint n;
			n = counts[g*2+s];
			m = 0;
			if (n == 0 || n < minimum)
				return 0;
			m = sums[g*2+s] / n;
			return 1;
		endfunction

		function bit [31:0] int_root(bit [63:0] v);
			bit [63:0] res = 0;
			bit [63:0] b = 64'h1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res[31:0];
		endfunction

		function void note_input(logic signed [RESP_W-1:0] resp, logic [CLASS_W-1:0] g,
				logic [SIDE_W-1:0] sd, logic lst);
			split_result_t r;
			longint ctl[2], eff[2], m, diff;
			int best[2];
			int k;
			bit ok;
			bit [63:0] mag;
			bit [127:0] prod;
			if (sd == SIDE_LEFT || sd == SIDE_RIGHT) begin
				k = g * 2 + (sd == SIDE_RIGHT);
				if (sd == SIDE_LEFT && left_n != 16'hFFFF)
					left_n++;
				if (sd == SIDE_RIGHT && right_n != 16'hFFFF)
					right_n++;
				if (counts[k] != 16'hFFFF) begin
					counts[k]++;
					sums[k] += longint'(resp);
				end
			end
			if (!lst)
				return;
			best = '{0, 0};
			eff = '{0, 0};
			r = '0;
			ok = mean_of(0, 0, min_ctl, ctl[0]);
			ok = ok && mean_of(0, 1, min_ctl, ctl[1]);
			if (ok) begin
				for (int c = 1; c <= classes; c++)
					for (int s = 0; s < 2; s++)
						if (mean_of(c, s, min_trt, m) && (best[s] == 0 || eff[s] < m - ctl[s])) begin
							eff[s] = m - ctl[s];
							best[s] = c;
						end
				r.split_ok = best[0] != 0 && best[1] != 0 && left_n >= min_side &&
					right_n >= min_side;
			end
			if (r.split_ok) begin
				diff = eff[0] - eff[1];
				mag = diff < 0 ? -diff : diff;
				prod = int_root({32'(left_n * right_n), 32'h0}) * mag;
				prod = prod >> FRAC_W;
				r.score = prod > 128'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : prod[47:0];
			end
			r.left_n = left_n;
			r.right_n = right_n;
			r.best_l = CLASS_W'(best[0]);
			r.best_r = CLASS_W'(best[1]);
			r.eff_l = eff[0][EFF_W-1:0];
			r.eff_r = eff[1][EFF_W-1:0];
			pending.push_back(r);
			clear_node();
		endfunction

		function void check(split_result_t got);
			split_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.score !== want.score || got.split_ok !== want.split_ok ||
					got.left_n !== want.left_n || got.right_n !== want.right_n ||
					got.best_l !== want.best_l || got.best_r !== want.best_r ||
					got.eff_l !== want.eff_l || got.eff_r !== want.eff_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch\n  expected %p\n  actual   %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [RESP_W-1:0] response = '0;
	logic [CLASS_W-1:0] group = '0;
	logic [SIDE_W-1:0] side = '0;
	logic last = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	logic [SCORE_W-1:0] score;
	logic split_valid;
	logic [TOTAL_W-1:0] left_total, right_total;
	logic [CLASS_W-1:0] best_class_left, best_class_right;
	logic signed [EFF_W-1:0] effect_left, effect_right;

	split_board board = new();
	int idle_pct = 20;
	int cycles = 0;
	int cur_classes = 1;

	uplift_split_score_top dut (.*);

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 3_000_000) begin
			$display("uplift_split_score_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			board.check({score, split_valid, left_total, right_total, best_class_left,
				best_class_right, effect_left, effect_right});

	// Holds start high into the next beat when no gap is drawn.
	task automatic send(logic [31:0] resp, int g, int sd, bit lst);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1;
		response <= resp;
		group <= CLASS_W'(g);
		side <= SIDE_W'(sd);
		last <= lst;
		do @(posedge clk); while (busy);
		board.note_input(resp, CLASS_W'(g), SIDE_W'(sd), lst);
	endtask

	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (board.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		if (idx == REG_TREATMENT_CLASSES)
			cur_classes = int'(data[CLASS_W-1:0]);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic configure(int cls, int ms, int mc, int mt);
		write_reg(REG_TREATMENT_CLASSES, CFG_DATA_W'(cls));
		write_reg(REG_MIN_SIDE_OBS, CFG_DATA_W'(ms));
		write_reg(REG_MIN_CONTROL_OBS, CFG_DATA_W'(mc));
		write_reg(REG_MIN_TREATMENT_OBS, CFG_DATA_W'(mt));
		// Unused indexes must leave every register alone.
		write_reg(CFG_IDX_W'(4 + $urandom_range(11)), CFG_DATA_W'($urandom));
	endtask

	function automatic logic [31:0] rand_resp();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return $urandom_range(4, 0) << 16;
			default: return 32'($signed($urandom_range(400000)) - 200000);
		endcase
	endfunction

	task automatic random_node(int len);
		int g, sd;
		bit tidy;
		tidy = $urandom_range(99) < 80;
		if (tidy) begin
			send(rand_resp(), 0, SIDE_LEFT, 0);
			send(rand_resp(), 0, SIDE_RIGHT, 0);
		end
		for (int i = 0; i < len; i++) begin
			if (tidy) begin
				g = $urandom_range(3) == 0 ? 0 : $urandom_range(cur_classes > 0 ? cur_classes : 1);
				sd = $urandom_range(9) == 0 ? 0 : $urandom_range(2, 1);
			end else begin
				g = $urandom_range(15);
				sd = $urandom_range(3);
			end
			send(rand_resp(), g, sd, i == len - 1);
		end
		if (len == 0)
			send(rand_resp(), $urandom_range(15), $urandom_range(3), 1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset settings: one treatment class, minimums of one.
		send(32'h7FFF_FFFF, 0, SIDE_LEFT, 0);
		send(32'h8000_0000, 0, SIDE_RIGHT, 0);
		send(32'h0001_0000, 1, SIDE_LEFT, 0);
		send(32'hFFFF_0000, 1, SIDE_RIGHT, 1);
		// Control missing on the right.
		send(32'h0000_0005, 0, SIDE_LEFT, 0);
		send(32'h0000_0007, 1, SIDE_LEFT, 0);
		send(32'h0000_0009, 1, SIDE_RIGHT, 1);
		// No treatment on the right; side three and a class above the setting.
		send(32'h0002_0000, 0, SIDE_LEFT, 0);
		send(32'h0003_0000, 0, SIDE_RIGHT, 0);
		send(32'h0004_0000, 1, SIDE_LEFT, 0);
		send(32'h1234_5678, 1, 3, 0);
		send(32'h0100_0000, 5, SIDE_RIGHT, 0);
		send(32'h0000_0000, 0, 0, 1);
		// Empty node.
		send(32'hFFFF_FFFF, 15, 0, 1);
		settle();

		// All classes, zero minimums: ties go to the lower class.
		configure(15, 0, 0, 0);
		send(32'h0000_0001, 0, SIDE_LEFT, 0);
		send(32'hFFFF_FFFF, 0, SIDE_RIGHT, 0);
		send(32'h0005_0000, 3, SIDE_LEFT, 0);
		send(32'h0005_0000, 7, SIDE_LEFT, 0);
		send(32'hFFFF_FFFD, 15, SIDE_RIGHT, 0);
		send(32'hFFFF_FFFD, 2, SIDE_RIGHT, 0);
		send(32'h7FFF_FFFF, 15, SIDE_LEFT, 1);
		settle();

		for (int p = 0; p < 6; p++) begin
			idle_pct = p < 2 ? 20 : p < 4 ? 75 : 0;
			case (p)
				0: configure(3, 1, 1, 1);
				1: configure(0, 0, 0, 0);
				2: configure(15, 65535, 65535, 65535);
				3: configure($urandom_range(15), $urandom_range(3), $urandom_range(2),
					$urandom_range(2));
				4: configure($urandom_range(1, 15), $urandom_range(2), 1, $urandom_range(1));
				default: configure(15, 2, 1, 2);
			endcase
			for (int n = 0; n < 200; ) begin
				int len;
				len = $urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(12, 2);
				random_node(len);
				n += len + 2;
			end
			settle();
		end

		// A long node with extreme responses on both sides.
		idle_pct = 0;
		configure(1, 1, 1, 1);
		send(32'h0000_0000, 0, SIDE_LEFT, 0);
		send(32'h0000_0000, 0, SIDE_RIGHT, 0);
		for (int i = 0; i < 30; i++)
			send(32'h7FFF_FFFF, 1, SIDE_LEFT, 0);
		for (int i = 0; i < 30; i++)
			send(32'h8000_0000, 1, SIDE_RIGHT, 0);
		send(32'h0000_0000, 0, 0, 1);
		settle();

		if (board.errors == 0)
			$display("uplift_split_score_top regression: pass");
		else
			$display("uplift_split_score_top regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
rtl/core/uss_pkg.sv
rtl/core/uss_store.sv
rtl/core/uss_div.sv
rtl/core/uss_sqrt.sv
rtl/core/uplift_split_score_top.sv
tb/testbench.sv
